### rtl/ccia_pkg.sv
// Shared constants, types and conversion helpers for the checked C integer ALU.
package ccia_pkg;

    localparam int MAX_WIDTH_DEF = 64;

    localparam logic [1:0] KIND_UNS  = 2'd0;
    localparam logic [1:0] KIND_SGN  = 2'd1;
    localparam logic [1:0] KIND_BOOL = 2'd2;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_OVF   = 3'd1;
    localparam logic [2:0] ST_DIV0  = 3'd2;
    localparam logic [2:0] ST_SHIFT = 3'd3;
    localparam logic [2:0] ST_CLZ0  = 3'd4;

    localparam logic [4:0] OP_ADD  = 5'd0;
    localparam logic [4:0] OP_SUB  = 5'd1;
    localparam logic [4:0] OP_MUL  = 5'd2;
    localparam logic [4:0] OP_DIV  = 5'd3;
    localparam logic [4:0] OP_REM  = 5'd4;
    localparam logic [4:0] OP_AND  = 5'd5;
    localparam logic [4:0] OP_XOR  = 5'd6;
    localparam logic [4:0] OP_OR   = 5'd7;
    localparam logic [4:0] OP_SHL  = 5'd8;
    localparam logic [4:0] OP_SHR  = 5'd9;
    localparam logic [4:0] OP_EQ   = 5'd10;
    localparam logic [4:0] OP_NE   = 5'd11;
    localparam logic [4:0] OP_LT   = 5'd12;
    localparam logic [4:0] OP_LE   = 5'd13;
    localparam logic [4:0] OP_GT   = 5'd14;
    localparam logic [4:0] OP_GE   = 5'd15;
    localparam logic [4:0] OP_LAND = 5'd16;
    localparam logic [4:0] OP_LOR  = 5'd17;
    localparam logic [4:0] OP_LNOT = 5'd18;
    localparam logic [4:0] OP_NOT  = 5'd19;
    localparam logic [4:0] OP_NEG  = 5'd20;
    localparam logic [4:0] OP_CONV = 5'd21;
    localparam logic [4:0] OP_CLZ  = 5'd22;

    localparam logic [1:0] MODE_MUL = 2'd0;
    localparam logic [1:0] MODE_DIV = 2'd1;
    localparam logic [1:0] MODE_CLZ = 2'd2;

    typedef struct packed {
        logic       start;
        logic [1:0] mode;
    } t_iter_cmd;

    typedef struct packed {
        logic done;
    } t_iter_rsp;

    function automatic logic [63:0] mask_of(input logic [6:0] w);
        mask_of = {64{1'b1}} >> (7'd64 - w);
    endfunction

    function automatic logic [6:0] fix_width(input logic [6:0] w, input logic [6:0] maxw);
        if (w == 7'd0) begin
            fix_width = 7'd1;
        end else if (w > maxw) begin
            fix_width = maxw;
        end else begin
            fix_width = w;
        end
    endfunction

    function automatic logic [1:0] fix_kind(input logic [1:0] k);
        fix_kind = (k == KIND_SGN || k == KIND_BOOL) ? k : KIND_UNS;
    endfunction

    function automatic logic [63:0] norm(input logic [63:0] bits, input logic [6:0] w,
                                         input logic [1:0] k);
        if (k == KIND_BOOL) begin
            norm = {63'd0, |bits};
        end else begin
            norm = bits & mask_of(w);
        end
    endfunction

    function automatic logic [63:0] sext(input logic [63:0] bits, input logic [6:0] w);
        logic [5:0] idx;
        idx = 6'(w - 7'd1);
        sext = bits[idx] ? (bits | ~mask_of(w)) : bits;
    endfunction

    function automatic logic [63:0] convert(input logic [63:0] bits, input logic [6:0] w,
                                            input logic [1:0] k, input logic [6:0] ow,
                                            input logic [1:0] ok);
        logic [63:0] v;
        v = norm(bits, w, k);
        if (ok == KIND_BOOL) begin
            convert = {63'd0, |v};
        end else begin
            if (k == KIND_SGN) begin
                v = sext(v, w);
            end
            convert = norm(v, ow, ok);
        end
    endfunction

endpackage

### rtl/checked_c_integer_alu_top.sv
// Top level of the checked C integer ALU: operand conversion, sequencer and result logic.
// One item is accepted when start is high and busy is low; its result appears on
// o_result_value and o_status for one cycle marked by o_done, and the receiver cannot
// stall it. Most operations pass through the prepare and execute states after acceptance.
// Multiply, divide and remainder then run the 64 steps of the shared radix-2 shift-add
// and subtract unit; a divide by zero or a signed division overflow is reported without
// starting the unit. Count leading zeros shifts the operand in the unit until its top bit
// is set, and a zero operand is reported without starting it. Busy is high from acceptance
// until the strobe cycle, and the next item can be accepted at the edge that ends it.
module checked_c_integer_alu_top #(
    parameter int MAX_WIDTH = ccia_pkg::MAX_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [4:0]  i_req_type,
    input  logic [63:0] i_left_value,
    input  logic [6:0]  i_left_width,
    input  logic [1:0]  i_left_kind,
    input  logic [63:0] i_right_value,
    input  logic [6:0]  i_right_width,
    input  logic [1:0]  i_right_kind,
    input  logic [6:0]  i_op_width,
    input  logic [1:0]  i_op_kind,
    output logic        o_done,
    output logic [63:0] o_result_value,
    output logic [2:0]  o_status
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PREP = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;
    localparam logic [1:0] S_WAIT = 2'd3;

    localparam logic [6:0] MAXW = 7'(MAX_WIDTH);

    logic [1:0]  r_state;
    logic [1:0]  n_state;
    logic        r_done;
    logic        n_done;
    logic [63:0] r_res;
    logic [2:0]  r_st;

    logic [4:0]  r_op;
    logic [63:0] r_lv;
    logic [63:0] r_rv;
    logic [6:0]  r_lw;
    logic [6:0]  r_rw;
    logic [6:0]  r_ow;
    logic [1:0]  r_lk;
    logic [1:0]  r_rk;
    logic [1:0]  r_ok;

    logic [63:0] r_x;
    logic [63:0] r_y;
    logic [5:0]  r_sh;
    logic        r_sh_bad;
    logic        r_lnz;
    logic        r_rnz;
    logic [63:0] r_clzv;

    logic [63:0] p_a;
    logic [63:0] p_b;
    logic [63:0] p_lnorm;
    logic [63:0] p_rnorm;
    logic [63:0] p_c;

    logic        sgn;
    logic [63:0] mask;
    logic [63:0] a;
    logic [63:0] smin;
    logic [63:0] smax;
    logic [63:0] ma;
    logic [63:0] mb;
    logic        neg;
    logic [63:0] s;
    logic        ovf;
    logic        slt;
    logic        sgt;
    logic [63:0] lim;
    logic [63:0] q;
    logic [63:0] rm;
    logic [63:0] ev_res;
    logic [2:0]  ev_st;
    logic [63:0] fin_res;
    logic [2:0]  fin_st;

    ccia_pkg::t_iter_cmd cmd;
    ccia_pkg::t_iter_rsp rsp;
    logic [63:0]         u_a;
    logic [63:0]         u_b;
    logic [63:0]         u_hi;
    logic [63:0]         u_lo;
    logic [6:0]          u_count;

    ccia_iter_unit u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_op_a  (u_a),
        .i_op_b  (u_b),
        .o_rsp   (rsp),
        .o_hi    (u_hi),
        .o_lo    (u_lo),
        .o_count (u_count)
    );

    always_comb begin
        p_a     = ccia_pkg::convert(r_lv, r_lw, r_lk, r_ow, r_ok);
        p_b     = ccia_pkg::convert(r_rv, r_rw, r_rk, r_ow, r_ok);
        p_lnorm = ccia_pkg::norm(r_lv, r_lw, r_lk);
        p_rnorm = ccia_pkg::norm(r_rv, r_rw, r_rk);
        p_c     = (r_rk == ccia_pkg::KIND_SGN) ? ccia_pkg::sext(p_rnorm, r_rw) : p_rnorm;
    end

    always_comb begin
        sgn  = (r_ok == ccia_pkg::KIND_SGN);
        mask = ccia_pkg::mask_of(r_ow);
        a    = r_x & mask;
        smin = {64{1'b1}} << (r_ow - 7'd1);
        smax = mask >> 1;
        ma   = (sgn && r_x[63]) ? (64'd0 - r_x) : r_x;
        mb   = (sgn && r_y[63]) ? (64'd0 - r_y) : r_y;
        neg  = r_x[63] ^ r_y[63];
        s    = (r_op == ccia_pkg::OP_ADD) ? (r_x + r_y) : (r_x - r_y);
        if (r_op == ccia_pkg::OP_ADD) begin
            ovf = ((r_x ^ s) & (r_y ^ s)) >> 63 != 64'd0;
        end else begin
            ovf = ((r_x ^ r_y) & (r_x ^ s)) >> 63 != 64'd0;
        end
        ovf = ovf || (ccia_pkg::sext(s & mask, r_ow) != s);
        slt = sgn ? ($signed(r_x) < $signed(r_y)) : (r_x < r_y);
        sgt = sgn ? ($signed(r_y) < $signed(r_x)) : (r_y < r_x);
        lim = (64'd1 << (r_ow - 7'd1)) - (neg ? 64'd0 : 64'd1);
        q   = (sgn && neg) ? (64'd0 - u_lo) : u_lo;
        rm  = (sgn && r_x[63]) ? (64'd0 - u_hi) : u_hi;
    end

    always_comb begin
        ev_res = 64'd0;
        ev_st  = ccia_pkg::ST_OK;
        cmd    = '0;
        u_a    = ma;
        u_b    = mb;
        case (r_op)
            ccia_pkg::OP_ADD, ccia_pkg::OP_SUB: begin
                if (sgn && ovf) begin
                    ev_st = ccia_pkg::ST_OVF;
                end else begin
                    ev_res = ccia_pkg::norm(s, r_ow, r_ok);
                end
            end
            ccia_pkg::OP_MUL: begin
                cmd.mode = ccia_pkg::MODE_MUL;
            end
            ccia_pkg::OP_DIV, ccia_pkg::OP_REM: begin
                cmd.mode = ccia_pkg::MODE_DIV;
                if (r_y == 64'd0) begin
                    ev_st = ccia_pkg::ST_DIV0;
                end else if (sgn && r_x == smin && r_y == {64{1'b1}}) begin
                    ev_st = ccia_pkg::ST_OVF;
                end
            end
            ccia_pkg::OP_AND: ev_res = ccia_pkg::norm(a & r_y, r_ow, r_ok);
            ccia_pkg::OP_XOR: ev_res = ccia_pkg::norm((a ^ r_y) & mask, r_ow, r_ok);
            ccia_pkg::OP_OR:  ev_res = ccia_pkg::norm((a | r_y) & mask, r_ow, r_ok);
            ccia_pkg::OP_SHL: begin
                if (r_sh_bad) begin
                    ev_st = ccia_pkg::ST_SHIFT;
                end else if (sgn && (r_x[63] || a > (smax >> r_sh))) begin
                    ev_st = ccia_pkg::ST_OVF;
                end else begin
                    ev_res = ccia_pkg::norm(a << r_sh, r_ow, r_ok);
                end
            end
            ccia_pkg::OP_SHR: begin
                if (r_sh_bad) begin
                    ev_st = ccia_pkg::ST_SHIFT;
                end else if (sgn && r_x[63]) begin
                    ev_res = ccia_pkg::norm($unsigned($signed(r_x) >>> r_sh), r_ow, r_ok);
                end else begin
                    ev_res = ccia_pkg::norm(a >> r_sh, r_ow, r_ok);
                end
            end
            ccia_pkg::OP_EQ:   ev_res = {63'd0, r_x == r_y};
            ccia_pkg::OP_NE:   ev_res = {63'd0, r_x != r_y};
            ccia_pkg::OP_LT:   ev_res = {63'd0, slt};
            ccia_pkg::OP_LE:   ev_res = {63'd0, !sgt};
            ccia_pkg::OP_GT:   ev_res = {63'd0, sgt};
            ccia_pkg::OP_GE:   ev_res = {63'd0, !slt};
            ccia_pkg::OP_LAND: ev_res = {63'd0, r_lnz && r_rnz};
            ccia_pkg::OP_LOR:  ev_res = {63'd0, r_lnz || r_rnz};
            ccia_pkg::OP_LNOT: ev_res = {63'd0, !r_lnz};
            ccia_pkg::OP_NOT:  ev_res = ccia_pkg::norm(~a, r_ow, r_ok);
            ccia_pkg::OP_NEG: begin
                if (sgn && r_x == smin) begin
                    ev_st = ccia_pkg::ST_OVF;
                end else begin
                    ev_res = ccia_pkg::norm(64'd0 - a, r_ow, r_ok);
                end
            end
            ccia_pkg::OP_CONV: ev_res = a;
            ccia_pkg::OP_CLZ: begin
                cmd.mode = ccia_pkg::MODE_CLZ;
                u_a      = r_clzv;
                if (!r_lnz) begin
                    ev_st = ccia_pkg::ST_CLZ0;
                end
            end
            default: ev_res = 64'd0;
        endcase
        cmd.start = (r_state == S_EXEC) && (ev_st == ccia_pkg::ST_OK) &&
                    (r_op == ccia_pkg::OP_MUL || r_op == ccia_pkg::OP_DIV ||
                     r_op == ccia_pkg::OP_REM || r_op == ccia_pkg::OP_CLZ);
    end

    always_comb begin
        fin_res = 64'd0;
        fin_st  = ccia_pkg::ST_OK;
        case (r_op)
            ccia_pkg::OP_MUL: begin
                if (!sgn) begin
                    fin_res = ccia_pkg::norm(u_lo, r_ow, r_ok);
                end else if (u_hi != 64'd0 || u_lo > lim) begin
                    fin_st = ccia_pkg::ST_OVF;
                end else begin
                    fin_res = ccia_pkg::norm(neg ? (64'd0 - u_lo) : u_lo, r_ow, r_ok);
                end
            end
            ccia_pkg::OP_DIV: fin_res = ccia_pkg::norm(q, r_ow, r_ok);
            ccia_pkg::OP_REM: fin_res = ccia_pkg::norm(rm, r_ow, r_ok);
            default:          fin_res = ccia_pkg::norm({57'd0, u_count}, r_ow, r_ok);
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        case (r_state)
            S_IDLE: if (start) n_state = S_PREP;
            S_PREP: n_state = S_EXEC;
            S_EXEC: begin
                if (cmd.start) begin
                    n_state = S_WAIT;
                end else begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end
            end
            S_WAIT: begin
                if (rsp.done) begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_op <= i_req_type;
            r_lv <= i_left_value;
            r_rv <= i_right_value;
            r_lw <= ccia_pkg::fix_width(i_left_width, MAXW);
            r_rw <= ccia_pkg::fix_width(i_right_width, MAXW);
            r_ow <= ccia_pkg::fix_width(i_op_width, MAXW);
            r_lk <= ccia_pkg::fix_kind(i_left_kind);
            r_rk <= ccia_pkg::fix_kind(i_right_kind);
            r_ok <= ccia_pkg::fix_kind(i_op_kind);
        end
        if (r_state == S_PREP) begin
            r_x      <= (r_ok == ccia_pkg::KIND_SGN) ? ccia_pkg::sext(p_a, r_ow) : p_a;
            r_y      <= (r_ok == ccia_pkg::KIND_SGN) ? ccia_pkg::sext(p_b, r_ow) : p_b;
            r_sh     <= p_c[5:0];
            r_sh_bad <= (r_rk == ccia_pkg::KIND_SGN && p_c[63]) || (p_c >= {57'd0, r_ow});
            r_lnz    <= (p_lnorm != 64'd0);
            r_rnz    <= (p_rnorm != 64'd0);
            r_clzv   <= p_lnorm << (7'd64 - r_lw);
        end
        if (r_state == S_EXEC && !cmd.start) begin
            r_res <= (ev_st == ccia_pkg::ST_OK) ? ev_res : 64'd0;
            r_st  <= ev_st;
        end else if (r_state == S_WAIT && rsp.done) begin
            r_res <= (fin_st == ccia_pkg::ST_OK) ? fin_res : 64'd0;
            r_st  <= fin_st;
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_result_value = r_res;
    assign o_status       = r_st;

`ifndef ASSERT_OFF
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not make the block busy");
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe lasted more than one cycle");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status != ccia_pkg::ST_OK |-> o_result_value == 64'd0)
        else $error("error result carries a nonzero value");
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_status <= ccia_pkg::ST_CLZ0)
        else $error("status code out of range");
    a_unit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp.done |-> r_state == S_WAIT)
        else $error("iterative unit finished outside the wait state");
`endif

endmodule

### rtl/ccia_iter_unit.sv
// Shared iterative unit: shift-add multiply, restoring divide and leading-zero count.
module ccia_iter_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ccia_pkg::t_iter_cmd i_cmd,
    input  logic [63:0]         i_op_a,
    input  logic [63:0]         i_op_b,
    output ccia_pkg::t_iter_rsp o_rsp,
    output logic [63:0]         o_hi,
    output logic [63:0]         o_lo,
    output logic [6:0]          o_count
);

    logic        r_busy;
    logic        r_done;
    logic [1:0]  r_mode;
    logic [5:0]  r_step;
    logic [63:0] r_hi;
    logic [63:0] r_lo;
    logic [63:0] r_b;
    logic [6:0]  r_count;

    logic [64:0] x;
    logic [64:0] y;
    logic        cin;
    logic [65:0] sum;
    logic        last;
    logic        clz_hit;

    always_comb begin
        if (r_mode == ccia_pkg::MODE_DIV) begin
            x   = {r_hi, r_lo[63]};
            y   = ~{1'b0, r_b};
            cin = 1'b1;
        end else begin
            x   = {1'b0, r_hi};
            y   = r_lo[0] ? {1'b0, r_b} : 65'd0;
            cin = 1'b0;
        end
        sum     = {1'b0, x} + {1'b0, y} + {65'd0, cin};
        last    = (r_step == 6'd63);
        clz_hit = r_hi[63];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if ((r_mode == ccia_pkg::MODE_CLZ) ? clz_hit : last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_mode  <= i_cmd.mode;
            r_step  <= 6'd0;
            r_count <= 7'd0;
            case (i_cmd.mode)
                ccia_pkg::MODE_MUL: begin
                    r_hi <= 64'd0;
                    r_lo <= i_op_b;
                    r_b  <= i_op_a;
                end
                ccia_pkg::MODE_DIV: begin
                    r_hi <= 64'd0;
                    r_lo <= i_op_a;
                    r_b  <= i_op_b;
                end
                default: begin
                    r_hi <= i_op_a;
                    r_lo <= 64'd0;
                    r_b  <= 64'd0;
                end
            endcase
        end else if (r_busy) begin
            r_step <= r_step + 6'd1;
            case (r_mode)
                ccia_pkg::MODE_MUL: begin
                    r_hi <= sum[64:1];
                    r_lo <= {sum[0], r_lo[63:1]};
                end
                ccia_pkg::MODE_DIV: begin
                    if (sum[65]) begin
                        r_hi <= sum[63:0];
                        r_lo <= {r_lo[62:0], 1'b1};
                    end else begin
                        r_hi <= x[63:0];
                        r_lo <= {r_lo[62:0], 1'b0};
                    end
                end
                default: begin
                    if (!clz_hit) begin
                        r_hi    <= {r_hi[62:0], 1'b0};
                        r_count <= r_count + 7'd1;
                    end
                end
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_hi       = r_hi;
    assign o_lo       = r_lo;
    assign o_count    = r_count;

endmodule
